[rtl/core/salc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and helpers for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

   // access kinds
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_STORE  = 2'd1;
   localparam logic [1:0] FUNC_MODIFY = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS_USED  = 2'd2;

   localparam logic [2:0] SET_BITS_RST   = 3'd4;
   localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [3:0] WAYS_USED_RST  = 4'd1;

   // way index field wide enough for the largest supported way count (32)
   localparam int WAY_IDX_W = 5;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic        last;
      logic [31:0] hits_total;
      logic [31:0] misses_total;
      logic [31:0] evictions_total;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [31:0] stamp;
   } line_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_IDX_W-1:0] hit_way;
      logic                 free;
      logic [WAY_IDX_W-1:0] free_way;
   } match_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_SCAN,
      ST_DONE
   } state_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage
`default_nettype wire

[rtl/core/salc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/core/salc_way_match.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// salc_way_match
// Tag compare across the ways of one set; first hit and first free way.
// ----------------------------------------------------------------------------
module salc_way_match #(
   parameter int MAX_WAYS = 8
) (
   input  wire salc_pkg::line_type [MAX_WAYS-1:0]        row,
   input  wire logic [31:0]                              tag,
   input  wire logic [$clog2(MAX_WAYS+1)-1:0]            nways,
   output salc_pkg::match_type                           match
);

   always_comb begin
      match = '0;
      // walk downward so the lowest matching way wins
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (32'(w) < 32'(nways)) begin
            if (row[w].valid && row[w].tag == tag) begin
               match.hit     = 1'b1;
               match.hit_way = salc_pkg::WAY_IDX_W'(w);
            end
            if (!row[w].valid) begin
               match.free     = 1'b1;
               match.free_way = salc_pkg::WAY_IDX_W'(w);
            end
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/set_assoc_lru_cache_sim_core.sv]
`default_nettype none
// Flow: a load or store reads its set row from IDLE, picks a way in LOOK and
//   loads its result in DONE; a miss on a full set runs the LRU victim scan first.
//   A modify then goes through READ, LOOK (plus any scan) and DONE for its second result.
// Requests are taken only in IDLE, after the last result; DONE waits out rsp_stall.
// Reset: a clearing pass writes every set row (2^MAX_SET_BITS rows, 64 by
//   default), with req_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Set-associative cache simulator with LRU replacement and running counters.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // access requests
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire salc_pkg::req_type req_data,
   // access results
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output salc_pkg::rsp_type      rsp_data,
   // configuration writes
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [4:0]        csr_data
);

   // one RAM row holds all ways of a set
   localparam int DEPTH  = 1 << MAX_SET_BITS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NW_W   = $clog2(MAX_WAYS + 1);
   localparam int LINE_W = $bits(salc_pkg::line_type);
   localparam int ROW_W  = MAX_WAYS * LINE_W;

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; the user must write only
   // while the core is idle (not enforced), so values stay stable across an access.
   // ------------------------------------------------------------------------
   logic [2:0] set_bits_ff;
   logic [4:0] block_bits_ff;
   logic [3:0] ways_used_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RST;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
         ways_used_ff  <= salc_pkg::WAYS_USED_RST;
      end else if (csr_valid) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            salc_pkg::CSR_WAYS_USED:  ways_used_ff  <= csr_data[3:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // effective set bits and way count (out-of-range values clamp)
   logic [3:0]      sb;
   logic [NW_W-1:0] nways;

   always_comb begin
      if (32'(set_bits_ff) > MAX_SET_BITS) begin
         sb = 4'(MAX_SET_BITS);
      end else begin
         sb = {1'b0, set_bits_ff};
      end
      if (ways_used_ff == 4'd0) begin
         nways = NW_W'(1);
      end else if (32'(ways_used_ff) > MAX_WAYS) begin
         nways = NW_W'(MAX_WAYS);
      end else begin
         nways = NW_W'(ways_used_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Address split of the incoming request
   // ------------------------------------------------------------------------
   logic [5:0]    tag_shamt;
   logic [31:0]   addr_shift;
   logic [31:0]   set_mask;
   logic [AW-1:0] req_set;
   logic [31:0]   req_tag;

   always_comb begin
      tag_shamt  = 6'(block_bits_ff) + 6'(sb);
      addr_shift = req_data.address >> block_bits_ff;
      set_mask   = (32'd1 << sb) - 32'd1;
      req_set    = AW'(addr_shift & set_mask);
      req_tag    = (tag_shamt >= 6'd32) ? 32'd0 : (req_data.address >> tag_shamt);
   end

   // ------------------------------------------------------------------------
   // Control and datapath registers
   // ------------------------------------------------------------------------
   salc_pkg::state_type                 state_ff, state_in;
   logic [AW-1:0]                       clr_ff, clr_in;
   logic [AW-1:0]                       set_ff, set_in;
   logic [31:0]                         tag_ff, tag_in;
   logic                                modify_ff, modify_in;   // second access pending
   salc_pkg::line_type [MAX_WAYS-1:0]   row_ff, row_in;
   logic                                hit_ff, hit_in;
   logic                                evict_ff, evict_in;
   logic [WAY_W-1:0]                    victim_ff, victim_in;
   logic [WAY_W-1:0]                    scan_ff, scan_in;
   logic [31:0]                         min_stamp_ff, min_stamp_in;
   logic [31:0]                         use_clock_ff, use_clock_in;
   logic [31:0]                         hits_ff, hits_in;
   logic [31:0]                         misses_ff, misses_in;
   logic [31:0]                         evicts_ff, evicts_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   salc_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   // RAM interface
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [ROW_W-1:0]  ram_rd_data;

   salc_pkg::line_type [MAX_WAYS-1:0] row_rd;
   salc_pkg::line_type [MAX_WAYS-1:0] row_wr;
   salc_pkg::match_type               match;

   assign row_rd = ram_rd_data;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // tag compare on the row as it leaves the RAM
   salc_way_match #(
      .MAX_WAYS (MAX_WAYS)
   ) u_way_match (
      .row   (row_rd),
      .tag   (tag_ff),
      .nways (nways),
      .match (match)
   );

   // ------------------------------------------------------------------------
   // Sequencer
   //   IDLE : take a request, start the set read
   //   READ : start the set read for the second half of a modify
   //   LOOK : row arrives, pick hit / free way or start the LRU scan
   //   SCAN : one way per cycle, keep the smallest stamp (lowest way on ties)
   //   DONE : write the row back and load the result once the slot is free
   // ------------------------------------------------------------------------
   logic             slot_free;
   logic [31:0]      clock_next;
   logic [31:0]      scan_stamp;
   logic [NW_W-1:0]  last_way;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign clock_next = use_clock_ff + 32'd1;
   assign scan_stamp = row_ff[scan_ff].stamp;
   assign last_way   = nways - NW_W'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      modify_in    = modify_ff;
      row_in       = row_ff;
      hit_in       = hit_ff;
      evict_in     = evict_ff;
      victim_in    = victim_ff;
      scan_in      = scan_ff;
      min_stamp_in = min_stamp_ff;
      use_clock_in = use_clock_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      req_stall    = (state_ff != salc_pkg::ST_IDLE);

      ram_wr_en    = 1'b0;
      ram_wr_addr  = set_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = set_ff;

      row_wr            = row_ff;
      row_wr[victim_ff] = '{valid: 1'b1, tag: tag_ff, stamp: clock_next};
      ram_wr_data       = row_wr;

      case (state_ff)
         salc_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end

         salc_pkg::ST_IDLE: begin
            if (req_valid && req_data.func != salc_pkg::FUNC_NONE) begin
               set_in      = req_set;
               tag_in      = req_tag;
               modify_in   = (req_data.func == salc_pkg::FUNC_MODIFY);
               ram_rd_en   = 1'b1;
               ram_rd_addr = req_set;
               state_in    = salc_pkg::ST_LOOK;
            end
         end

         salc_pkg::ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = salc_pkg::ST_LOOK;
         end

         salc_pkg::ST_LOOK: begin
            row_in       = row_rd;
            hit_in       = match.hit;
            evict_in     = 1'b0;
            scan_in      = WAY_W'(1);
            min_stamp_in = row_rd[0].stamp;
            if (match.hit) begin
               victim_in = WAY_W'(match.hit_way);
               state_in  = salc_pkg::ST_DONE;
            end else if (match.free) begin
               victim_in = WAY_W'(match.free_way);
               state_in  = salc_pkg::ST_DONE;
            end else begin
               victim_in = '0;
               evict_in  = 1'b1;
               state_in  = (nways == NW_W'(1)) ? salc_pkg::ST_DONE : salc_pkg::ST_SCAN;
            end
         end

         salc_pkg::ST_SCAN: begin
            if (scan_stamp < min_stamp_ff) begin
               victim_in    = scan_ff;
               min_stamp_in = scan_stamp;
            end
            scan_in = scan_ff + WAY_W'(1);
            if (NW_W'(scan_ff) == last_way) begin
               state_in = salc_pkg::ST_DONE;
            end
         end

         salc_pkg::ST_DONE: begin
            if (slot_free) begin
               ram_wr_en    = 1'b1;
               use_clock_in = clock_next;
               if (hit_ff) begin
                  hits_in = salc_pkg::sat_inc(hits_ff);
               end else begin
                  misses_in = salc_pkg::sat_inc(misses_ff);
               end
               if (evict_ff) begin
                  evicts_in = salc_pkg::sat_inc(evicts_ff);
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.hit             = hit_ff;
               rsp_data_in.evicted         = evict_ff;
               rsp_data_in.last            = !modify_ff;
               rsp_data_in.hits_total      = hit_ff ? salc_pkg::sat_inc(hits_ff) : hits_ff;
               rsp_data_in.misses_total    = hit_ff ? misses_ff : salc_pkg::sat_inc(misses_ff);
               rsp_data_in.evictions_total = evict_ff ? salc_pkg::sat_inc(evicts_ff)
                                                      : evicts_ff;
               modify_in = 1'b0;
               // the write lands before the next read is issued
               state_in  = modify_ff ? salc_pkg::ST_READ : salc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         modify_ff    <= 1'b0;
         use_clock_ff <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         modify_ff    <= modify_in;
         use_clock_ff <= use_clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      row_ff       <= row_in;
      hit_ff       <= hit_in;
      evict_ff     <= evict_in;
      victim_ff    <= victim_in;
      scan_ff      <= scan_in;
      min_stamp_ff <= min_stamp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
